/* rtl/sorted_priority_queue_core_defines.svh */
// assertion macros used by the checker file
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/spq_pkg.sv */
package spq_pkg;

   // queue depth and derived widths
   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int CNT_W    = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;

   // request codes
   typedef enum logic [0:0] {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic      push;
      logic      pop;
      value_type value;
   } cell_ctl_type;

endpackage

/* rtl/spq_req_if.sv */
interface spq_req_if;
   logic                    valid;
   logic                    ready;
   logic [0:0]              req_type;
   logic signed [31:0]      value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

/* rtl/spq_rsp_if.sv */
interface spq_rsp_if;
   logic                    valid;
   logic                    ready;
   logic signed [31:0]      smallest;
   logic signed [31:0]      largest;
   logic [4:0]              occupancy;
   logic                    is_empty;
   logic [1:0]              status;

   modport source (output valid, output smallest, output largest, output occupancy,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input smallest, input largest, input occupancy,
                   input is_empty, input status, output ready);
endinterface

/* rtl/spq_cell.sv */
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                 occupied,
   input  logic                 left_keep,
   input  spq_pkg::value_type   left_value,
   input  spq_pkg::value_type   right_value,
   output logic                 keep,
   output spq_pkg::value_type   value,
   output spq_pkg::value_type   value_next
);

   spq_pkg::value_type entry_ff;
   spq_pkg::value_type entry_in;

   // entry stays in place when it is stored and not above the pushed value
   assign keep = occupied && (entry_ff <= ctl.value);

   // shift right on insert, shift left on pop
   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.push) begin
         priority if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctl.value;
         end else begin
            entry_in = left_value;
         end
      end else if (ctl.pop) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value      = entry_ff;
   assign value_next = entry_in;

endmodule

/* rtl/sorted_priority_queue_core.sv */
// Sorted minimum priority queue of spq_pkg::CAPACITY signed 32-bit values, held in a row
// of cells in ascending order; equal values leave in arrival order. Each push or pop
// item is finished by the cell row at the edge that accepts it and its result is held in an
// output register, so the block takes one item per cycle; req ready is low during reset
// and while a result waits in that register and rsp ready is low. A result appears in the
// cycle after its item. Pop on an empty queue and push on a full queue change nothing and
// are reported in status. Stored values are undefined after reset, but only entries
// below the count are ever shown.
module sorted_priority_queue_core (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam int CAP = spq_pkg::CAPACITY;

   spq_pkg::count_type    count_ff;
   spq_pkg::count_type    count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   spq_pkg::value_type    smallest_ff;
   spq_pkg::value_type    smallest_in;
   spq_pkg::value_type    largest_ff;
   spq_pkg::value_type    largest_in;
   spq_pkg::count_type    occupancy_ff;
   logic                  is_empty_ff;
   spq_pkg::status_type   status_ff;
   spq_pkg::status_type   status_in;

   logic                  accept;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   spq_pkg::cell_ctl_type ctl;

   logic                  keep   [CAP];
   logic                  occ    [CAP];
   spq_pkg::value_type    value  [CAP];
   spq_pkg::value_type    vnext  [CAP];
   spq_pkg::value_type    last_sel [CAP];

   // handshake
   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign is_pop       = (req_if.req_type == spq_pkg::REQ_POP);
   assign full         = (count_ff == spq_pkg::CNT_W'(CAP));
   assign empty        = (count_ff == '0);

   // operation broadcast
   always_comb begin
      ctl.push  = accept && !is_pop && !full;
      ctl.pop   = accept && is_pop && !empty;
      ctl.value = req_if.value;
   end

   // count and status
   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::STATUS_OK;
      priority if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
      priority if (is_pop && empty) begin
         status_in = spq_pkg::STATUS_POP_EMPTY;
      end else if (!is_pop && full) begin
         status_in = spq_pkg::STATUS_PUSH_FULL;
      end else begin
         status_in = spq_pkg::STATUS_OK;
      end
   end

   // cell row
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      assign occ[i] = (spq_pkg::CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ[i]),
         .left_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
         .left_value  (value[(i == 0) ? 0 : i-1]),
         .right_value (value[(i == CAP-1) ? CAP-1 : i+1]),
         .keep        (keep[i]),
         .value       (value[i]),
         .value_next  (vnext[i])
      );

      // pick the new tail entry
      assign last_sel[i] = (count_in == spq_pkg::CNT_W'(i + 1)) ? vnext[i] : '0;
   end

   // front and back of the queue after the item
   always_comb begin
      largest_in = '0;
      for (int i = 0; i < CAP; i++) begin
         largest_in = largest_in | last_sel[i];
      end
      smallest_in = (count_in == '0) ? '0 : vnext[0];
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         smallest_ff  <= smallest_in;
         largest_ff   <= largest_in;
         occupancy_ff <= count_in;
         is_empty_ff  <= (count_in == '0);
         status_ff    <= status_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.smallest  = smallest_ff;
   assign rsp_if.largest   = largest_ff;
   assign rsp_if.occupancy = occupancy_ff;
   assign rsp_if.is_empty  = is_empty_ff;
   assign rsp_if.status    = status_ff;

endmodule

/* rtl/spq_checker.sv */
`include "sorted_priority_queue_core_defines.svh"

module spq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_smallest,
   input logic signed [31:0] rsp_largest,
   input logic [4:0]         rsp_occupancy,
   input logic               rsp_is_empty,
   input logic [1:0]         rsp_status
);

   // an accepted item yields a result on the next cycle
   `SPQ_ASSERT_NEXT(a_item_yields_result, clock, reset, req_valid && req_ready, rsp_valid)

   // a stalled result keeps its payload
   `SPQ_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_smallest) && $stable(rsp_largest) && $stable(rsp_occupancy) && $stable(rsp_status))

   // empty flag agrees with occupancy, and occupancy stays within capacity
   `SPQ_ASSERT_IMPLY(a_empty_matches, clock, reset, rsp_valid, (rsp_is_empty == (rsp_occupancy == 5'd0)) && (rsp_occupancy <= 5'(spq_pkg::CAPACITY)))

   // a non-empty queue is ordered front to back
   `SPQ_ASSERT_IMPLY(a_front_not_above_back, clock, reset, rsp_valid && !rsp_is_empty, rsp_smallest <= rsp_largest)

   // a pop on an empty queue leaves it empty
   `SPQ_ASSERT_IMPLY(a_pop_empty_stays, clock, reset, rsp_valid && (rsp_status == spq_pkg::STATUS_POP_EMPTY), rsp_is_empty)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_smallest  (rsp_if.smallest),
   .rsp_largest   (rsp_if.largest),
   .rsp_occupancy (rsp_if.occupancy),
   .rsp_is_empty  (rsp_if.is_empty),
   .rsp_status    (rsp_if.status)
);
